// File: sv/cvh_pkg.sv
// ----------------------------------------------------------------------------
// cvh_pkg
// Types, widths and codes shared by the convex hull block.
// ----------------------------------------------------------------------------
package cvh_pkg;

  // Capacity and coordinate width
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int MIN_UNIQUE = 3;
  localparam int STK_DEPTH  = 2 * MAX_POINTS;

  // Derived widths
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int STK_AW     = $clog2(STK_DEPTH);
  localparam int TOP_W      = $clog2(STK_DEPTH + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CTOL_W     = 8;
  localparam int TTOL_W     = 20;
  localparam int TURN_W     = (PROD_W + 1 > TTOL_W + 1) ? PROD_W + 1 : TTOL_W + 1;
  localparam int FIELD_W    = 16;

  // Configuration port
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam logic [0:0] REG_COORD_TOL = 1'b0;
  localparam logic [0:0] REG_TURN_TOL  = 1'b1;

  typedef logic signed [FIELD_W-1:0]    field_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [TURN_W-1:0]     turn_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_shift;
    logic ins_put;
    logic dd_init;
    logic dd_rd;
    logic dd_cmp;
    logic h_init;
    logic h_rd;
    logic h_load;
    logic h_mul;
    logic h_pop;
    logic h_popw;
    logic h_push;
    logic e_rd;
    logic e_load;
    logic e_err;
    logic e_next;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic last;
    logic j_zero;
    logic less;
    logic dd_done;
    logic u_small;
    logic can_test;
    logic turn_le;
    logic hull_last;
    logic out_taken;
    logic out_last;
  } sts_t;

endpackage

// File: sv/cvh_in_if.sv
// ----------------------------------------------------------------------------
// cvh_in_if
// Point input channel: one point per transfer.
// ----------------------------------------------------------------------------
interface cvh_in_if;
  import cvh_pkg::*;

  logic   valid;
  logic   ready;
  field_t point_x;
  field_t point_y;
  logic   last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// File: sv/cvh_out_if.sv
// ----------------------------------------------------------------------------
// cvh_out_if
// Hull vertex output channel: one vertex or error result per transfer.
// ----------------------------------------------------------------------------
interface cvh_out_if;
  import cvh_pkg::*;

  logic    valid;
  logic    ready;
  field_t  vertex_x;
  field_t  vertex_y;
  logic    last_vertex;
  status_t status;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  output status, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  input status, output ready);
endinterface

// File: sv/convex_hull_monotone_chain_top.sv
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain_top
// Convex hull of a point set by the monotone chain method.
// ----------------------------------------------------------------------------
// Points enter on in_ch, one per transfer, until a transfer with last_point
// set. Each point that fits is inserted into a sorted store as it arrives,
// shifting up every stored point that sorts after it, and the input is ready
// again once the insertion is done. After the last point the store is swept
// once to drop near-duplicates, then the lower and upper chains are built on
// the hull stack with the single shared cross-product unit and the one-port
// stack memory. Hull vertices leave on out_ch counterclockwise from the
// leftmost point, each read out only after the one before it was taken; the
// last one has last_vertex set. A set with fewer than three unique points
// yields a single result with status 1.
// A stalled receiver simply holds the output register; no input is taken
// until the whole result of a set has been transferred.
// Reset clears the point count, the stack pointer and the tolerances; the
// stores need no clearing. The tolerances are to be written over cfg_ only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain_top (
  input  logic                          clk,
  input  logic                          rst_n,
  cvh_in_if.sink                        in_ch,
  cvh_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cvh_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [cvh_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [cvh_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import cvh_pkg::*;

  logic [CTOL_W-1:0] coord_tol_r;
  logic [TTOL_W-1:0] turn_tol_r;
  logic [0:0]        reg_idx;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_tol_r <= '0;
      turn_tol_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        REG_COORD_TOL: coord_tol_r <= cfg_pwdata[CTOL_W-1:0];
        REG_TURN_TOL:  turn_tol_r  <= cfg_pwdata[TTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_COORD_TOL: cfg_prdata = CFG_DW'(coord_tol_r);
      REG_TURN_TOL:  cfg_prdata = CFG_DW'(turn_tol_r);
      default:       cfg_prdata = '0;
    endcase
  end

  cvh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cvh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .coord_tol  (coord_tol_r),
    .turn_tol   (turn_tol_r),
    .in_x       (in_ch.point_x),
    .in_y       (in_ch.point_y),
    .in_last    (in_ch.last_point),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_x      (out_ch.vertex_x),
    .out_y      (out_ch.vertex_y),
    .out_last   (out_ch.last_vertex),
    .out_status (out_ch.status)
  );

endmodule

// File: sv/cvh_ctrl.sv
// ----------------------------------------------------------------------------
// cvh_ctrl
// Sequencer: load with insertion, duplicate removal, chain building, output.
// ----------------------------------------------------------------------------
module cvh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cvh_pkg::sts_t sts,
  output cvh_pkg::cmd_t cmd
);
  import cvh_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_LOADED  = 17'h00002,
    S_INS_CHK = 17'h00004,
    S_INS_CMP = 17'h00008,
    S_DD_INIT = 17'h00010,
    S_DD_RD   = 17'h00020,
    S_DD_CMP  = 17'h00040,
    S_DD_END  = 17'h00080,
    S_H_RD    = 17'h00100,
    S_H_LOAD  = 17'h00200,
    S_H_TEST  = 17'h00400,
    S_H_CMP   = 17'h00800,
    S_H_POPW  = 17'h01000,
    S_H_PUSH  = 17'h02000,
    S_E_RD    = 17'h04000,
    S_E_LOAD  = 17'h08000,
    S_E_WAIT  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOADED;
        end
      end
      S_LOADED: begin
        if (!sts.full) state_nxt = S_INS_CHK;
        else if (sts.last) state_nxt = S_DD_INIT;
        else state_nxt = S_IDLE;
      end
      S_INS_CHK: begin
        if (sts.j_zero) begin
          cmd.ins_put = 1'b1;
          state_nxt   = sts.last ? S_DD_INIT : S_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.less) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_CHK;
        end else begin
          cmd.ins_put = 1'b1;
          state_nxt   = sts.last ? S_DD_INIT : S_IDLE;
        end
      end
      S_DD_INIT: begin
        cmd.dd_init = 1'b1;
        state_nxt   = S_DD_RD;
      end
      S_DD_RD: begin
        if (sts.dd_done) begin
          state_nxt = S_DD_END;
        end else begin
          cmd.dd_rd = 1'b1;
          state_nxt = S_DD_CMP;
        end
      end
      S_DD_CMP: begin
        cmd.dd_cmp = 1'b1;
        state_nxt  = S_DD_RD;
      end
      S_DD_END: begin
        if (sts.u_small) begin
          cmd.e_err = 1'b1;
          state_nxt = S_E_WAIT;
        end else begin
          cmd.h_init = 1'b1;
          state_nxt  = S_H_RD;
        end
      end
      S_H_RD: begin
        cmd.h_rd  = 1'b1;
        state_nxt = S_H_LOAD;
      end
      S_H_LOAD: begin
        cmd.h_load = 1'b1;
        state_nxt  = S_H_TEST;
      end
      S_H_TEST: begin
        if (sts.can_test) begin
          cmd.h_mul = 1'b1;
          state_nxt = S_H_CMP;
        end else begin
          state_nxt = S_H_PUSH;
        end
      end
      S_H_CMP: begin
        if (sts.turn_le) begin
          cmd.h_pop = 1'b1;
          state_nxt = S_H_POPW;
        end else begin
          state_nxt = S_H_PUSH;
        end
      end
      S_H_POPW: begin
        cmd.h_popw = 1'b1;
        state_nxt  = S_H_TEST;
      end
      S_H_PUSH: begin
        cmd.h_push = 1'b1;
        state_nxt  = sts.hull_last ? S_E_RD : S_H_RD;
      end
      S_E_RD: begin
        cmd.e_rd  = 1'b1;
        state_nxt = S_E_LOAD;
      end
      S_E_LOAD: begin
        cmd.e_load = 1'b1;
        state_nxt  = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (sts.out_taken) begin
          if (sts.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.e_next = 1'b1;
            state_nxt  = S_E_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: sv/cvh_dp.sv
// ----------------------------------------------------------------------------
// cvh_dp
// Datapath: point store, hull stack, cross-product unit and output register.
// ----------------------------------------------------------------------------
module cvh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cvh_pkg::cmd_t                 cmd,
  output cvh_pkg::sts_t                 sts,
  input  logic [cvh_pkg::CTOL_W-1:0]    coord_tol,
  input  logic [cvh_pkg::TTOL_W-1:0]    turn_tol,
  input  cvh_pkg::field_t               in_x,
  input  cvh_pkg::field_t               in_y,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cvh_pkg::field_t               out_x,
  output cvh_pkg::field_t               out_y,
  output logic                          out_last,
  output cvh_pkg::status_t              out_status
);
  import cvh_pkg::*;

  // Memories
  point_t pts_mem [MAX_POINTS];
  point_t stk_mem [STK_DEPTH];
  point_t pts_rd_r;
  point_t stk_rd_r;

  // Control registers
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              last_r;
  logic [TOP_W-1:0]  top_r;
  logic              out_v_r;

  // Working registers
  point_t            p_r, keep_r, c_r, t1_r, t2_r;
  logic [IDX_W-1:0]  j_r, h_r;
  logic [CNT_W-1:0]  i_r, u_r;
  logic [TOP_W-1:0]  floor_r, e_r;
  logic              phase_r;
  prod_t             prod_a_r, prod_b_r;
  field_t            ox_r, oy_r;
  logic              olast_r;
  status_t           ost_r;

  // Tolerance test signals
  diff_t             dx, dy;
  logic [DIFF_W-1:0] ax, ay;
  logic              keep;

  // Point store address and write selection
  logic [IDX_W-1:0]  pts_ra, pts_wa;
  point_t            pts_wd;
  logic              pts_we, pts_re;

  always_comb begin
    pts_re = cmd.ins_rd | cmd.dd_rd | cmd.h_rd;
    pts_ra = h_r;
    if (cmd.ins_rd) pts_ra = j_r - 1'b1;
    else if (cmd.dd_rd) pts_ra = i_r[IDX_W-1:0];
    pts_we = cmd.ins_shift | cmd.ins_put | (cmd.dd_cmp & keep);
    pts_wa = u_r[IDX_W-1:0];
    pts_wd = pts_rd_r;
    if (cmd.ins_shift) begin
      pts_wa = j_r;
    end else if (cmd.ins_put) begin
      pts_wa = j_r;
      pts_wd = p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pts_we) pts_mem[pts_wa] <= pts_wd;
    if (pts_re) pts_rd_r <= pts_mem[pts_ra];
  end

  // Hull stack: push at the top, read below it after a pop or for output
  logic [STK_AW-1:0] stk_ra;
  assign stk_ra = cmd.h_pop ? STK_AW'(top_r - TOP_W'(3)) : e_r[STK_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.h_push) stk_mem[top_r[STK_AW-1:0]] <= c_r;
    if (cmd.h_pop | cmd.e_rd) stk_rd_r <= stk_mem[stk_ra];
  end

  // Lexicographic compare of the new point against the stored one
  logic less;
  assign less = (p_r.x < pts_rd_r.x) || ((p_r.x == pts_rd_r.x) && (p_r.y < pts_rd_r.y));

  // Tolerance test against the last kept point
  always_comb begin
    dx   = diff_t'(pts_rd_r.x) - diff_t'(keep_r.x);
    dy   = diff_t'(pts_rd_r.y) - diff_t'(keep_r.y);
    ax   = dx[DIFF_W-1] ? -dx : dx;
    ay   = dy[DIFF_W-1] ? -dy : dy;
    keep = (u_r == '0) || (ax > DIFF_W'(coord_tol)) || (ay > DIFF_W'(coord_tol));
  end

  // Cross-product operands; the products are registered
  diff_t bx, by, cx, cy;
  assign bx = diff_t'(t1_r.x) - diff_t'(t2_r.x);
  assign by = diff_t'(t1_r.y) - diff_t'(t2_r.y);
  assign cx = diff_t'(c_r.x) - diff_t'(t2_r.x);
  assign cy = diff_t'(c_r.y) - diff_t'(t2_r.y);

  turn_t turn;
  assign turn = turn_t'(prod_a_r) - turn_t'(prod_b_r);

  // Status towards the controller
  always_comb begin
    sts.full      = (cnt_r == CNT_W'(MAX_POINTS));
    sts.last      = last_r;
    sts.j_zero    = (j_r == '0);
    sts.less      = less;
    sts.dd_done   = (i_r == cnt_r);
    sts.u_small   = (u_r < CNT_W'(MIN_UNIQUE));
    sts.can_test  = (top_r >= floor_r + TOP_W'(2));
    sts.turn_le   = (turn <= turn_t'($signed({1'b0, turn_tol})));
    sts.hull_last = phase_r && (h_r == '0);
    sts.out_taken = out_v_r && out_ready;
    sts.out_last  = olast_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      top_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_r <= in_last;
        if (cnt_r == CNT_W'(MAX_POINTS)) ovf_r <= 1'b1;
      end
      if (cmd.ins_put) cnt_r <= cnt_r + 1'b1;
      if (cmd.h_init) top_r <= '0;
      if (cmd.h_pop) top_r <= top_r - 1'b1;
      if (cmd.h_push) top_r <= top_r + 1'b1;
      if (cmd.e_load | cmd.e_err) out_v_r <= 1'b1;
      else if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (cmd.finish) begin
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        top_r  <= '0;
        last_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r.x <= coord_t'(in_x);
      p_r.y <= coord_t'(in_y);
      j_r   <= cnt_r[IDX_W-1:0];
    end
    if (cmd.ins_shift) j_r <= j_r - 1'b1;
    if (cmd.dd_init) begin
      i_r <= '0;
      u_r <= '0;
    end
    if (cmd.dd_cmp) begin
      i_r <= i_r + 1'b1;
      if (keep) begin
        u_r    <= u_r + 1'b1;
        keep_r <= pts_rd_r;
      end
    end
    if (cmd.h_init) begin
      h_r     <= '0;
      phase_r <= 1'b0;
      floor_r <= '0;
      e_r     <= '0;
    end
    if (cmd.h_load) c_r <= pts_rd_r;
    if (cmd.h_mul) begin
      prod_a_r <= bx * cy;
      prod_b_r <= by * cx;
    end
    if (cmd.h_pop) t1_r <= t2_r;
    if (cmd.h_popw) t2_r <= stk_rd_r;
    // Push, then step to the next point of the lower or upper chain
    if (cmd.h_push) begin
      t2_r <= t1_r;
      t1_r <= c_r;
      if (!phase_r) begin
        if ({1'b0, h_r} == u_r - 1'b1) begin
          phase_r <= 1'b1;
          h_r     <= IDX_W'(u_r - CNT_W'(2));
          floor_r <= top_r;
        end else begin
          h_r <= h_r + 1'b1;
        end
      end else begin
        h_r <= h_r - 1'b1;
      end
    end
    if (cmd.e_next) e_r <= e_r + 1'b1;
    // Output register
    if (cmd.e_load) begin
      ox_r    <= field_t'(stk_rd_r.x);
      oy_r    <= field_t'(stk_rd_r.y);
      olast_r <= (e_r + TOP_W'(2) == top_r) || (e_r == TOP_W'(MAX_POINTS - 1));
      ost_r   <= ovf_r ? ST_DROP : ST_OK;
    end
    if (cmd.e_err) begin
      ox_r    <= '0;
      oy_r    <= '0;
      olast_r <= 1'b1;
      ost_r   <= ST_FEW;
    end
  end

  assign out_valid  = out_v_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_last   = olast_r;
  assign out_status = ost_r;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull block testbench
// Drives point sets into the hull block and checks every vertex it emits.
// A behavioural hull builder computes the expected vertices of each set when
// its last point is transferred; the block's outputs are compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import cvh_pkg::*;

  typedef struct {
    field_t  vx;
    field_t  vy;
    logic    lastv;
    status_t st;
  } vertex_rec_t;

  typedef struct {
    longint x;
    longint y;
  } hpt_t;

  // Scoreboard: keeps a copy of the block state and the expected vertices
  class hull_scoreboard;
    hpt_t          pending[$];
    bit            dropped;
    int unsigned   ctol;
    int unsigned   ttol;
    vertex_rec_t   expected_vertices[$];
    int            mismatches;

    function new();
      ctol = 0;
      ttol = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function longint turn_of(hpt_t a, hpt_t b, hpt_t c);
      return (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
    endfunction

    function void note_point(field_t px, field_t py, logic lastp);
      hpt_t p;
      hpt_t srt[$];
      hpt_t uniq[$];
      hpt_t stk[$];
      hpt_t t;
      int j;
      int lower_len;
      status_t st;
      vertex_rec_t r;
      p.x = px;
      p.y = py;
      if (pending.size() < MAX_POINTS) pending = {pending, p};
      else dropped = 1;
      if (!lastp) return;
      // Insertion sort by x, then y
      foreach (pending[i]) begin
        t = pending[i];
        j = srt.size();
        srt = {srt, t};
        while (j > 0 && (t.x < srt[j-1].x || (t.x == srt[j-1].x && t.y < srt[j-1].y))) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = t;
      end
      // Drop near-duplicates against the last kept point
      foreach (srt[i]) begin
        if (uniq.size() == 0 ||
            (srt[i].x - uniq[$].x > longint'(ctol) ||
             uniq[$].x - srt[i].x > longint'(ctol)) ||
            (srt[i].y - uniq[$].y > longint'(ctol) ||
             uniq[$].y - srt[i].y > longint'(ctol)))
          uniq = {uniq, srt[i]};
      end
      st = dropped ? ST_DROP : ST_OK;
      pending.delete();
      dropped = 0;
      if (uniq.size() < MIN_UNIQUE) begin
        r.vx = '0; r.vy = '0; r.lastv = 1; r.st = ST_FEW;
        expected_vertices = {expected_vertices, r};
        return;
      end
      // Lower chain, then upper chain
      for (int i = 0; i < uniq.size(); i++) begin
        while (stk.size() >= 2 && turn_of(stk[$-1], stk[$], uniq[i]) <= longint'(ttol))
          stk = stk[0:$-1];
        stk = {stk, uniq[i]};
      end
      lower_len = stk.size();
      for (int i = uniq.size() - 2; i >= 0; i--) begin
        while (stk.size() >= lower_len + 1 &&
               turn_of(stk[$-1], stk[$], uniq[i]) <= longint'(ttol))
          stk = stk[0:$-1];
        stk = {stk, uniq[i]};
      end
      for (int i = 0; i + 1 < stk.size() && i < MAX_POINTS; i++) begin
        r.vx = field_t'(stk[i].x);
        r.vy = field_t'(stk[i].y);
        r.lastv = (i + 2 == stk.size()) || (i + 1 == MAX_POINTS);
        r.st = st;
        expected_vertices = {expected_vertices, r};
      end
    endfunction

    function void check_vertex(field_t vx, field_t vy, logic lastv, status_t st);
      vertex_rec_t e;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected vertex x=%0d y=%0d last=%0b status=%0d", vx, vy, lastv, st);
        return;
      end
      e = expected_vertices.pop_front();
      if (e.vx !== vx || e.vy !== vy || e.lastv !== lastv || e.st !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Vertex mismatch: expected x=%0d y=%0d last=%0b status=%0d, ",
                    "got x=%0d y=%0d last=%0b status=%0d"},
                   e.vx, e.vy, e.lastv, e.st, vx, vy, lastv, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  cvh_in_if  in_ch ();
  cvh_out_if out_ch ();

  convex_hull_monotone_chain_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  hull_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  longint cycle_count;

  // Clock, 4 ns period
  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready = 0;
    hold_off_cycles = 0;
  end
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_vertex(out_ch.vertex_x, out_ch.vertex_y, out_ch.last_vertex, out_ch.status);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Input monitor feeds the scoreboard on each accepted transfer
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_point(in_ch.point_x, in_ch.point_y, in_ch.last_point);
  end

  // Send one point and wait for its transfer; valid stays high for the next one
  task automatic send_point(input field_t px, input field_t py, input logic lastp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.last_point <= lastp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Wait until every expected vertex has arrived, then let the block settle
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.expected_vertices.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Setup and access phases of one register write; the caller ends the access
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic set_tolerances(input int unsigned ct, input int unsigned tt);
    write_reg(CFG_AW'(4 * REG_COORD_TOL), CFG_DW'(ct));
    write_reg(CFG_AW'(4 * REG_TURN_TOL), CFG_DW'(tt));
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.ctol = ct;
    sb.ttol = tt;
  endtask

  // Random set; mostly small sets near a centre, sometimes full-range values
  task automatic send_random_set(input int npts);
    field_t cx, cy, px, py;
    int spread;
    cx = field_t'($urandom);
    cy = field_t'($urandom);
    spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(4, 300);
    for (int i = 0; i < npts; i++) begin
      if (spread == 32767) begin
        px = field_t'($urandom);
        py = field_t'($urandom);
      end else begin
        px = cx + field_t'($urandom_range(0, spread));
        py = cy + field_t'($urandom_range(0, spread));
      end
      send_point(px, py, i == npts - 1);
    end
  endtask

  int items;

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.last_point = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cfg_paddr = '0; cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, square, degenerate sets, duplicates
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh7fff, 0);
    send_point(16'sh8000, 16'sh7fff, 0);
    send_point(16'sh0000, 16'sh0000, 1);
    send_point(5, 5, 1);
    send_point(1, 1, 0);
    send_point(1, 1, 0);
    send_point(2, 2, 1);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(2, 2, 0);
    send_point(3, 3, 1);
    send_point(-1, 0, 0);
    send_point(0, -1, 0);
    send_point(1, 0, 1);
    drain();
    set_tolerances(255, 1048575);
    send_point(0, 0, 0);
    send_point(200, 100, 0);
    send_point(1000, 0, 0);
    send_point(500, 2000, 1);
    drain();
    set_tolerances(3, 10);
    // Overflow: more points than the store holds
    send_random_set(MAX_POINTS + 3);
    drain();

    // Random phases with different idling
    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 34 : 0;
      set_tolerances($urandom_range(0, 255) & ((ph == 0) ? 0 : 255),
                     (ph == 2) ? 1048575 : $urandom_range(0, 1048575) >> (4 * ph));
      if (ph == 1) hold_off_cycles = 600;
      for (int s = 0; s < 3; s++) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        send_random_set(n);
        items += n;
      end
      drain();
    end
    set_tolerances(0, 0);
    send_random_set(12);
    drain();

    if (sb.mismatches == 0 && sb.expected_vertices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
